// ===== rtl/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rfa_pkg: shared types, codes and helpers of the ring fork arbiter
// Widths, status and command codes, wait list entry and fork mask functions.
// ----------------------------------------------------------------------------
package rfa_pkg;

    localparam int MAX_DINERS = 16;
    localparam int ID_W       = $clog2(MAX_DINERS + 1);   // holds 0..MAX_DINERS
    localparam int IDX_W      = $clog2(MAX_DINERS);       // wait list index
    localparam int VAL_W      = 32;

    localparam logic [ID_W-1:0] MAX_ID    = ID_W'(MAX_DINERS);
    localparam logic [ID_W-1:0] MIN_RING  = ID_W'(2);
    localparam logic [4:0]      CFG_RESET = 5'd5;

    // command codes
    localparam logic CMD_REQ = 1'b0;
    localparam logic CMD_REL = 1'b1;

    // register index taken from paddr[2]
    localparam logic REG_DINER_COUNT = 1'b0;

    typedef logic [MAX_DINERS-1:0] t_forks;

    typedef enum logic [1:0] {
        ST_GRANT    = 2'd0,
        ST_QUEUED   = 2'd1,
        ST_RELEASED = 2'd2,
        ST_REJECT   = 2'd3
    } t_status;

    typedef struct packed {
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] value;
    } t_wait_entry;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  addr;
        t_wait_entry       data;
    } t_wl_wr;

    // clamp the configured diner count to 2..MAX_DINERS
    function automatic logic [ID_W-1:0] ring_size(input logic [4:0] cfg);
        logic [ID_W-1:0] n;
        n = ID_W'(cfg);
        if (cfg < 5'(MIN_RING)) begin
            n = MIN_RING;
        end else if (cfg > 5'(MAX_ID)) begin
            n = MAX_ID;
        end
        return n;
    endfunction

    // forks id-1 and id mod n; only meaningful for 1 <= id <= n
    function automatic t_forks fork_pair(input logic [ID_W-1:0] id,
                                         input logic [ID_W-1:0] n);
        t_forks          m;
        logic [ID_W-1:0] l;
        logic [ID_W-1:0] r;
        m = '0;
        l = id - ID_W'(1);
        r = (id == n) ? '0 : id;
        m[l[IDX_W-1:0]] = 1'b1;
        m[r[IDX_W-1:0]] = 1'b1;
        return m;
    endfunction

    // forks 0..n-1
    function automatic t_forks low_mask(input logic [ID_W-1:0] n);
        t_forks m;
        for (int i = 0; i < MAX_DINERS; i++) begin
            m[i] = (ID_W'(i) < n);
        end
        return m;
    endfunction

endpackage

// ===== rtl/rfa_wait_list.sv =====
// ----------------------------------------------------------------------------
// rfa_wait_list: storage of the waiting diners
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rfa_wait_list
    import rfa_pkg::*;
(
    input  logic              i_clk,
    input  t_wl_wr            i_wr,
    input  logic [IDX_W-1:0]  i_rd_addr,
    output t_wait_entry       o_rd_data
);

    t_wait_entry r_mem [MAX_DINERS];
    t_wait_entry r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read port, data valid in the cycle after the address
    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/ring_fork_arbiter.sv =====
// ----------------------------------------------------------------------------
// ring_fork_arbiter: central waiter handing out forks on a ring of diners
// Requests, releases, FIFO wait list with ordered rescan on release.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one command item: a
//   request to eat or a release, with diner id and value. Output channel
//   (o_out_valid / i_out_ready) returns one result item per command.
//   The APB port sets diner_count at address 0; pready is always high.
// Item flow:
//   A request or a bad id is resolved in the accept cycle; its result is
//   valid on the next cycle. A release with an empty wait list likewise, so
//   these items flow at one per cycle while the receiver keeps up.
//   A release otherwise walks the wait list one entry per cycle through the
//   single read port of the list memory, moving each entry behind a granted
//   waiter down one place in the same pass, then passes a closing state that
//   loads the result into the output register; no new item is accepted
//   until that closing state is done.
// Reset: synchronous, active low; forks free, list empty, sum and counters
//   zero, diner_count 5. The wait list memory needs no clearing.
// Stall: a finished result waits in the output register; the next item is
//   accepted in the cycle the held result is taken. The output register is
//   empty while a scan runs, so a scan never waits on the receiver.
// ----------------------------------------------------------------------------
module ring_fork_arbiter
    import rfa_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // APB configuration
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    // command items
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic              i_cmd,
    input  logic [ID_W-1:0]   i_diner_id,
    input  logic [VAL_W-1:0]  i_diner_value,
    // result items
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_status,
    output logic              o_grant_valid,
    output logic [ID_W-1:0]   o_granted_id,
    output logic [VAL_W-1:0]  o_running_sum,
    output logic [ID_W-1:0]   o_waiting_count,
    output logic              o_finished
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_FIN
    } t_state;

    // configuration register
    logic [4:0] r_diner_count;

    // control and arithmetic state
    t_state           r_state,   n_state;
    t_forks           r_forks,   n_forks;
    logic [ID_W-1:0]  r_fill,    n_fill;
    logic [ID_W-1:0]  r_seen,    n_seen;
    logic [VAL_W-1:0] r_sum,     n_sum;
    logic [ID_W-1:0]  r_idx,     n_idx;
    logic             r_pgv,     n_pgv;
    logic [ID_W-1:0]  r_pgid,    n_pgid;

    // output register
    logic             r_out_valid, n_out_valid;
    t_status          r_status,    n_status;
    logic             r_gvalid,    n_gvalid;
    logic [ID_W-1:0]  r_gid,       n_gid;
    logic [VAL_W-1:0] r_osum,      n_osum;
    logic [ID_W-1:0]  r_owait,     n_owait;
    logic             r_ofin,      n_ofin;

    t_wl_wr           wl_wr;
    logic [IDX_W-1:0] wl_rd_addr;
    t_wait_entry      wl_rd_data;

    logic [ID_W-1:0]  ring_n;
    logic             in_accept;
    logic             id_ok;
    t_forks           in_pair;
    logic             wait_ok;
    t_forks           wait_pair;
    logic             out_free;
    logic [ID_W-1:0]  idx_p1;
    logic [ID_W-1:0]  idx_p2;
    logic             cfg_write;

    rfa_wait_list u_wait_list (
        .i_clk     (i_clk),
        .i_wr      (wl_wr),
        .i_rd_addr (wl_rd_addr),
        .o_rd_data (wl_rd_data)
    );

    // APB register access
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_DINER_COUNT) ? {27'd0, r_diner_count} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_diner_count <= CFG_RESET;
        end else if (cfg_write && (paddr[2] == REG_DINER_COUNT)) begin
            r_diner_count <= pwdata[4:0];
        end
    end

    // decode of the incoming item and of the wait list entry under test
    assign ring_n     = ring_size(r_diner_count);
    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == S_IDLE) && out_free;
    assign in_accept  = i_in_valid && o_in_ready;
    assign id_ok      = (i_diner_id != '0) && (i_diner_id <= ring_n);
    assign in_pair    = fork_pair(i_diner_id, ring_n);
    assign wait_pair  = fork_pair(wl_rd_data.id, ring_n);
    assign wait_ok    = (wl_rd_data.id != '0) && (wl_rd_data.id <= ring_n)
                        && ((r_forks & wait_pair) == '0);
    assign idx_p1     = r_idx + ID_W'(1);
    assign idx_p2     = r_idx + ID_W'(2);

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_forks     = r_forks;
        n_fill      = r_fill;
        n_seen      = r_seen;
        n_sum       = r_sum;
        n_idx       = r_idx;
        n_pgv       = r_pgv;
        n_pgid      = r_pgid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_status    = r_status;
        n_gvalid    = r_gvalid;
        n_gid       = r_gid;
        n_osum      = r_osum;
        n_owait     = r_owait;
        n_ofin      = r_ofin;
        wl_wr       = '0;
        wl_rd_addr  = '0;

        case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_out_valid = 1'b1;
                    n_gvalid    = 1'b0;
                    n_gid       = '0;
                    if (!id_ok) begin
                        n_status = ST_REJECT;
                    end else if (i_cmd == CMD_REQ) begin
                        if ((r_forks & in_pair) == '0) begin
                            n_forks  = r_forks | in_pair;
                            n_sum    = r_sum + i_diner_value;
                            n_status = ST_GRANT;
                            n_gvalid = 1'b1;
                            n_gid    = i_diner_id;
                            if (r_seen < MAX_ID) begin
                                n_seen = r_seen + ID_W'(1);
                            end
                        end else if (r_fill < MAX_ID) begin
                            wl_wr.en         = 1'b1;
                            wl_wr.addr       = r_fill[IDX_W-1:0];
                            wl_wr.data.id    = i_diner_id;
                            wl_wr.data.value = i_diner_value;
                            n_fill   = r_fill + ID_W'(1);
                            n_status = ST_QUEUED;
                            if (r_seen < MAX_ID) begin
                                n_seen = r_seen + ID_W'(1);
                            end
                        end else begin
                            n_status = ST_REJECT;
                        end
                    end else begin
                        // release: free both forks, then rescan the list if it holds waiters
                        n_forks  = r_forks & ~in_pair;
                        n_status = ST_RELEASED;
                        n_pgv    = 1'b0;
                        n_pgid   = '0;
                        if (r_fill != '0) begin
                            n_out_valid = r_out_valid && !i_out_ready;
                            n_status    = r_status;
                            n_gvalid    = r_gvalid;
                            n_gid       = r_gid;
                            n_idx       = '0;
                            wl_rd_addr  = '0;
                            n_state     = S_SCAN;
                        end
                    end
                end
            end

            S_SCAN: begin
                // read data holds entry r_idx
                if (wait_ok) begin
                    n_forks = r_forks | wait_pair;
                    n_sum   = r_sum + wl_rd_data.value;
                    n_pgv   = 1'b1;
                    n_pgid  = wl_rd_data.id;
                    if (idx_p1 < r_fill) begin
                        wl_rd_addr = idx_p1[IDX_W-1:0];
                        n_state    = S_SHIFT;
                    end else begin
                        n_fill  = r_fill - ID_W'(1);
                        n_state = S_FIN;
                    end
                end else if (idx_p1 < r_fill) begin
                    wl_rd_addr = idx_p1[IDX_W-1:0];
                    n_idx      = idx_p1;
                end else begin
                    n_state = S_FIN;
                end
            end

            S_SHIFT: begin
                // read data holds entry r_idx+1, moved down one place
                wl_wr.en   = 1'b1;
                wl_wr.addr = r_idx[IDX_W-1:0];
                wl_wr.data = wl_rd_data;
                n_idx      = idx_p1;
                if (idx_p2 < r_fill) begin
                    wl_rd_addr = idx_p2[IDX_W-1:0];
                end else begin
                    n_fill  = r_fill - ID_W'(1);
                    n_state = S_FIN;
                end
            end

            S_FIN: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_status    = ST_RELEASED;
                    n_gvalid    = r_pgv;
                    n_gid       = r_pgid;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // summary fields follow the state after the step
        if (n_out_valid && !(r_out_valid && !i_out_ready)) begin
            n_osum  = n_sum;
            n_owait = n_fill;
            n_ofin  = (n_seen >= ring_n) && (n_fill == '0)
                      && ((n_forks & low_mask(ring_n)) == '0);
        end
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_forks     <= '0;
            r_fill      <= '0;
            r_seen      <= '0;
            r_sum       <= '0;
            r_idx       <= '0;
            r_pgv       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_forks     <= n_forks;
            r_fill      <= n_fill;
            r_seen      <= n_seen;
            r_sum       <= n_sum;
            r_idx       <= n_idx;
            r_pgv       <= n_pgv;
            r_out_valid <= n_out_valid;
        end
        r_pgid   <= n_pgid;
        r_status <= n_status;
        r_gvalid <= n_gvalid;
        r_gid    <= n_gid;
        r_osum   <= n_osum;
        r_owait  <= n_owait;
        r_ofin   <= n_ofin;
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_grant_valid   = r_gvalid;
    assign o_granted_id    = r_gid;
    assign o_running_sum   = r_osum;
    assign o_waiting_count = r_owait;
    assign o_finished      = r_ofin;

    // checks
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= MAX_ID)
        else $error("wait list fill above capacity");

    a_scan_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN || r_state == S_SHIFT) |-> (r_idx < r_fill))
        else $error("scan index outside the wait list");

    a_grant_has_id: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_grant_valid) |-> (o_granted_id != '0))
        else $error("grant reported without a diner id");

    a_queued_no_grant: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_QUEUED || o_status == ST_REJECT))
        |-> !o_grant_valid)
        else $error("grant reported on a queued or rejected item");

    a_release_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && id_ok && i_cmd == CMD_REL && r_fill != '0)
        |=> (r_state == S_SCAN))
        else $error("release with waiters did not start a scan");

endmodule

// ===== bench/ring_fork_arbiter_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_fork_arbiter_test: self-checking bench for the ring fork arbiter
// Drives request and release items through the valid/ready input channel and
// sets the ring size over the APB port. A behavioral copy of the waiter
// (forks, wait list, sum and counters) predicts the result of every accepted
// item; results are checked in order as they leave the output channel.
// ----------------------------------------------------------------------------
module ring_fork_arbiter_test;
    import rfa_pkg::*;

    localparam int         CYCLE_LIMIT      = 600000;
    localparam int         LONG_HOLD        = 300;
    localparam int         PHASE_ITEMS      = 105;
    localparam logic [2:0] ADDR_DINER_COUNT = {REG_DINER_COUNT, 2'b00};

    // one predicted waiter response
    typedef struct {
        t_status          status;
        logic             grant_valid;
        logic [ID_W-1:0]  granted_id;
        logic [VAL_W-1:0] sum;
        logic [ID_W-1:0]  waiting;
        logic             finished;
    } t_reply;

    // DUT inputs, all known from time zero
    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              psel          = 1'b0;
    logic              penable       = 1'b0;
    logic              pwrite        = 1'b0;
    logic [2:0]        paddr         = '0;
    logic [31:0]       pwdata        = '0;
    logic              i_in_valid    = 1'b0;
    logic              i_cmd         = CMD_REQ;
    logic [ID_W-1:0]   i_diner_id    = '0;
    logic [VAL_W-1:0]  i_diner_value = '0;
    logic              i_out_ready   = 1'b0;

    // DUT outputs
    logic [31:0]       prdata;
    logic              pready;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [1:0]        o_status;
    logic              o_grant_valid;
    logic [ID_W-1:0]   o_granted_id;
    logic [VAL_W-1:0]  o_running_sum;
    logic [ID_W-1:0]   o_waiting_count;
    logic              o_finished;

    // waiter copy
    logic [4:0]        ring_cfg = CFG_RESET;
    t_forks            forks_held = '0;
    logic [ID_W-1:0]   line_id [MAX_DINERS];
    logic [VAL_W-1:0]  line_val [MAX_DINERS];
    int                line_fill = 0;
    int                requests_counted = 0;
    logic [VAL_W-1:0]  value_total = '0;
    bit [MAX_DINERS:0] holding = '0;   // stimulus hint: who ate last

    t_reply            waiter_replies[$];
    int                fail_count = 0;
    int                cycle_count = 0;
    bit                calm = 1'b0;    // no idling on either side
    int                hold_requests = 0;

    ring_fork_arbiter u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_cmd           (i_cmd),
        .i_diner_id      (i_diner_id),
        .i_diner_value   (i_diner_value),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_status        (o_status),
        .o_grant_valid   (o_grant_valid),
        .o_granted_id    (o_granted_id),
        .o_running_sum   (o_running_sum),
        .o_waiting_count (o_waiting_count),
        .o_finished      (o_finished)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ring_fork_arbiter_test NOT OK");
            $finish;
        end
    end

    // effective ring size, clamped to 2..MAX_DINERS
    function automatic int active_ring();
        if (ring_cfg < 2) return 2;
        if (ring_cfg > MAX_DINERS) return MAX_DINERS;
        return int'(ring_cfg);
    endfunction

    // forks id-1 and id mod n
    function automatic t_forks ring_forks(input int id, input int n);
        t_forks m;
        m = '0;
        m[(id - 1) % n] = 1'b1;
        m[id % n] = 1'b1;
        return m;
    endfunction

    function automatic void grant_forks(input int id, input logic [VAL_W-1:0] val,
                                        input int n);
        forks_held |= ring_forks(id, n);
        value_total += val;
        holding[id] = 1'b1;
    endfunction

    // waiter behavior for one accepted item; updates the copied state
    function automatic t_reply serve_diner(input logic cmd, input logic [ID_W-1:0] id,
                                           input logic [VAL_W-1:0] val);
        t_reply r;
        int     n;
        int     hit;
        int     wid;
        n = active_ring();
        hit = -1;
        r.grant_valid = 1'b0;
        r.granted_id = '0;
        if (id == 0 || int'(id) > n) begin
            r.status = ST_REJECT;
        end else if (cmd == CMD_REQ) begin
            if ((forks_held & ring_forks(id, n)) == '0) begin
                grant_forks(id, val, n);
                r.status = ST_GRANT;
                r.grant_valid = 1'b1;
                r.granted_id = id;
                if (requests_counted < MAX_DINERS) requests_counted++;
            end else if (line_fill < MAX_DINERS) begin
                line_id[line_fill] = id;
                line_val[line_fill] = val;
                line_fill++;
                r.status = ST_QUEUED;
                if (requests_counted < MAX_DINERS) requests_counted++;
            end else begin
                r.status = ST_REJECT;
            end
        end else begin
            forks_held &= ~ring_forks(id, n);
            holding[id] = 1'b0;
            r.status = ST_RELEASED;
            // oldest waiter whose forks are free; stale ids are skipped
            for (int k = 0; k < line_fill; k++) begin
                wid = int'(line_id[k]);
                if (hit < 0 && wid != 0 && wid <= n &&
                    (forks_held & ring_forks(wid, n)) == '0) begin
                    hit = k;
                end
            end
            if (hit >= 0) begin
                grant_forks(line_id[hit], line_val[hit], n);
                r.grant_valid = 1'b1;
                r.granted_id = line_id[hit];
                for (int k = hit; k < line_fill - 1; k++) begin
                    line_id[k] = line_id[k + 1];
                    line_val[k] = line_val[k + 1];
                end
                line_fill--;
            end
        end
        r.sum = value_total;
        r.waiting = ID_W'(line_fill);
        r.finished = requests_counted >= n && line_fill == 0 &&
                     (forks_held & t_forks'((32'd1 << n) - 1)) == '0;
        return r;
    endfunction

    // receiver: random stalls, calm stretches, and long holds on request
    always @(posedge i_clk) begin : out_ready_drive
        int holds_begun;
        int hold_left;
        if (hold_requests != holds_begun) begin
            holds_begun = hold_requests;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= calm || ($urandom_range(0, 99) >= 25);
        end
    end

    // result checker
    always @(posedge i_clk) begin : result_check
        t_reply want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (waiter_replies.size() == 0) begin
                $error("result item with no item pending: status %0d", o_status);
                fail_count++;
            end else begin
                want = waiter_replies.pop_front();
                if (o_status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, o_status);
                    fail_count++;
                end
                if (o_grant_valid != want.grant_valid) begin
                    $error("grant_valid: expected %0d, got %0d", want.grant_valid,
                           o_grant_valid);
                    fail_count++;
                end
                if (o_granted_id != want.granted_id) begin
                    $error("granted_id: expected %0d, got %0d", want.granted_id,
                           o_granted_id);
                    fail_count++;
                end
                if (o_running_sum != want.sum) begin
                    $error("running_sum: expected %h, got %h", want.sum, o_running_sum);
                    fail_count++;
                end
                if (o_waiting_count != want.waiting) begin
                    $error("waiting_count: expected %0d, got %0d", want.waiting,
                           o_waiting_count);
                    fail_count++;
                end
                if (o_finished != want.finished) begin
                    $error("finished: expected %0d, got %0d", want.finished, o_finished);
                    fail_count++;
                end
            end
        end
    end

    // offer one item, possibly after an idle gap, and predict its result
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [VAL_W-1:0] val);
        t_reply reply;
        if (!calm && $urandom_range(0, 99) < 25) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_cmd         <= cmd;
        i_diner_id    <= id;
        i_diner_value <= val;
        do @(posedge i_clk); while (!o_in_ready);
        reply = serve_diner(cmd, id, val);
        waiter_replies.insert(waiter_replies.size(), reply);
    endtask

    // stop offering and wait for every pending result
    task automatic drain();
        i_in_valid <= 1'b0;
        while (waiter_replies.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write of diner_count: setup then access cycle
    task automatic write_diner_count(input logic [31:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_DINER_COUNT;
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        ring_cfg = v[4:0];
    endtask

    // random item: mostly valid ids, releases favor diners that hold forks
    task automatic send_random_item(input bit flood);
        int               n;
        int               pick;
        int               start;
        int               c;
        bit               found;
        logic             cmd;
        logic [ID_W-1:0]  id;
        logic [VAL_W-1:0] val;
        n = active_ring();
        pick = $urandom_range(0, 99);
        found = 1'b0;
        cmd = ($urandom_range(0, 99) < (flood ? 80 : 50)) ? CMD_REQ : CMD_REL;
        if (pick < 8) begin
            id = ID_W'($urandom_range(0, 31));
        end else begin
            id = ID_W'($urandom_range(1, n));
            if (cmd == CMD_REL && $urandom_range(0, 3) != 0) begin
                start = $urandom_range(1, n);
                for (int k = 0; k < n; k++) begin
                    c = ((start - 1 + k) % n) + 1;
                    if (!found && holding[c]) begin
                        id = ID_W'(c);
                        found = 1'b1;
                    end
                end
            end
        end
        case ($urandom_range(0, 7))
            0:       val = 32'h7FFF_FFFF;
            1:       val = 32'h8000_0000;
            2:       val = 32'hFFFF_FFFF;
            3:       val = 32'h0000_0000;
            default: val = $urandom;
        endcase
        send_item(cmd, id, val);
    endtask

    // reset ring of five: grants, queueing, bad ids, wrap, scan order, finish
    task automatic test_basic_ring();
        send_item(CMD_REQ, 5'd1, 32'h7FFF_FFFF);   // granted
        send_item(CMD_REQ, 5'd2, 32'h0000_0001);   // queued
        send_item(CMD_REQ, 5'd2, 32'h0000_0005);   // duplicate waiter
        send_item(CMD_REQ, 5'd0, 32'h1234_5678);   // bad id zero
        send_item(CMD_REQ, 5'd31, 32'hFFFF_FFFF);  // id above ring
        send_item(CMD_REL, 5'd6, 32'h0000_0000);   // bad release
        send_item(CMD_REQ, 5'd3, 32'h0000_0001);   // granted, sum sets bit 31
        send_item(CMD_REL, 5'd4, 32'h0000_0000);   // forks not held
        send_item(CMD_REL, 5'd1, 32'h0000_0000);   // waiter still blocked
        send_item(CMD_REL, 5'd3, 32'h0000_0000);   // oldest waiter granted
        send_item(CMD_REL, 5'd2, 32'h0000_0000);   // duplicate granted
        send_item(CMD_REL, 5'd2, 32'h0000_0000);   // empty list
        send_item(CMD_REQ, 5'd5, 32'h0000_0000);
        send_item(CMD_REL, 5'd5, 32'h0000_0000);   // finished
        drain();
    endtask

    // diner_count below and above range
    task automatic test_ring_clamp();
        write_diner_count(32'd0);
        send_item(CMD_REQ, 5'd2, 32'h0000_0010);
        send_item(CMD_REQ, 5'd3, 32'h0000_0020);
        send_item(CMD_REL, 5'd2, 32'h0000_0000);
        drain();
        write_diner_count(32'd31);
        send_item(CMD_REQ, 5'd16, 32'h8000_0000);
        send_item(CMD_REQ, 5'd17, 32'h0000_0001);
        send_item(CMD_REL, 5'd16, 32'h0000_0000);
        drain();
    endtask

    // a waiter left behind by a smaller ring is skipped, then served again
    task automatic test_stale_waiters();
        write_diner_count(32'd6);
        send_item(CMD_REQ, 5'd1, 32'h0000_0100);
        send_item(CMD_REQ, 5'd6, 32'h0000_0200);
        send_item(CMD_REQ, 5'd2, 32'h0000_0300);
        drain();
        write_diner_count(32'd4);
        send_item(CMD_REL, 5'd1, 32'h0000_0000);
        drain();
        write_diner_count(32'd6);
        send_item(CMD_REL, 5'd2, 32'h0000_0000);
        send_item(CMD_REL, 5'd6, 32'h0000_0000);
        drain();
    endtask

    // random traffic over a range of ring sizes
    task automatic test_random_traffic();
        logic [4:0] plan [12];
        plan = '{5'd2, 5'd16, 5'd5, 5'd3, 5'd0, 5'd31, 5'd9, 5'd17,
                 5'd1, 5'd12, 5'd2, 5'd16};
        for (int p = 0; p < 12; p++) begin
            write_diner_count(($urandom & 32'hFFFF_FFE0) | 32'(plan[p]));
            calm = (p == 6);
            repeat (PHASE_ITEMS) send_random_item(p % 4 == 0);
            drain();
        end
        calm = 1'b0;
    endtask

    // receiver holds off while the sender keeps offering back to back
    task automatic test_backpressure();
        write_diner_count(32'd4);
        calm = 1'b1;
        hold_requests++;
        repeat (24) send_random_item(1'b0);
        calm = 1'b0;
        drain();
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_basic_ring();
        test_ring_clamp();
        test_stale_waiters();
        test_random_traffic();
        test_backpressure();
        repeat (40) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("ring_fork_arbiter_test OK");
        end else begin
            $display("ring_fork_arbiter_test NOT OK");
        end
        $finish;
    end

endmodule

// ===== ring_fork_arbiter.f =====
rtl/rfa_pkg.sv
rtl/rfa_wait_list.sv
rtl/ring_fork_arbiter.sv
bench/ring_fork_arbiter_test.sv
